@@ rtl/fobs_pkg.sv @@
`default_nettype none

package fobs_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned WordW      = 32;

  typedef struct packed {
    logic                     mode;
    logic [AddrW-1:0]         address;
    logic signed [WordW-1:0]  data_word;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] position;
  } out_item_t;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_CHECK
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the accepted item's word into the table
    logic start;    // capture the key and open the range [0, count)
    logic rd_mid;   // read the table at the middle of the range
    logic rd_lo;    // read the table at the lower bound
    logic compare;  // narrow the range with the word just read
    logic finish;   // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic range_open;  // lower bound still below upper bound
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/first_occurrence_binary_search.sv @@
`default_nettype none

// Channel   Signals                               Moves
// input     in_valid_i, in_ready_o, in_item_i     load or search item
// output    out_valid_o, out_ready_i, out_item_o  one result per search item
// config    cfg_valid_i, cfg_ready_o, cfg_data_i  element count
//
// A load item writes its word into the table. A search item runs p probes (at
// most 11 for a full table) and a final read at the lower bound: each probe is one
// registered table read and one compare on the single read port.
// Reset clears the controller and the element count; the table is not cleared.
// A finished result waits in an output register; a new item is taken then,
// but a search that ends while that register is still full holds until it frees.

module first_occurrence_binary_search
  import fobs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_item_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  fobs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_item_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fobs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/fobs_ctrl.sv @@
`default_nettype none

module fobs_ctrl
  import fobs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_mode_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dp_cmd_t         cmd_o,
  input  wire dp_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.range_open) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = ST_COMPARE;
        end else begin
          cmd_o.rd_lo = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_PROBE;
      end
      ST_CHECK: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/fobs_dp.sv @@
`default_nettype none

module fobs_dp
  import fobs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_write_i,
  input  wire logic [CountW-1:0] cfg_data_i,
  input  wire in_item_t          in_item_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_status_t             status_o,
  output out_item_t              out_item_o
);

  logic signed [WordW-1:0] table_mem [TableDepth];
  logic signed [WordW-1:0] rdata_q;
  logic signed [WordW-1:0] key_q;
  logic [CountW-1:0]       count_q;
  logic [CountW-1:0]       eff_count;
  logic [CountW-1:0]       n_q;
  logic [CountW-1:0]       lo_q, lo_d;
  logic [CountW-1:0]       hi_q, hi_d;
  logic [CountW:0]         sum;
  logic [AddrW-1:0]        mid;
  logic [AddrW-1:0]        rd_addr;
  out_item_t               out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_write_i) begin
      count_q <= cfg_data_i;
    end
  end

  // A count above the table depth searches the whole table.
  assign eff_count = (count_q > CountW'(TableDepth)) ? CountW'(TableDepth) : count_q;

  // The middle never reaches the upper bound, so it fits a table address.
  assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = sum[AddrW:1];
  assign rd_addr = cmd_i.rd_lo ? lo_q[AddrW-1:0] : mid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      table_mem[in_item_i.address] <= in_item_i.data_word;
    end
    if (cmd_i.rd_mid || cmd_i.rd_lo) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = eff_count;
    end else if (cmd_i.compare) begin
      if (rdata_q < key_q) begin
        lo_d = {1'b0, mid} + CountW'(1);
      end else begin
        hi_d = {1'b0, mid};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.start) begin
      key_q <= in_item_i.data_word;
      n_q   <= eff_count;
    end
    if (cmd_i.finish) begin
      out_q.found    <= (lo_q < n_q) && (rdata_q == key_q);
      out_q.position <= lo_q;
    end
  end

  assign status_o.range_open = (lo_q < hi_q);
  assign out_item_o          = out_q;

endmodule

`default_nettype wire
